// ===== rtl/core/table_driven_expression_lexer_assert.svh =====
// assertion macros shared by the lexer rtl
`ifndef TABLE_DRIVEN_EXPRESSION_LEXER_ASSERT_SVH
`define TABLE_DRIVEN_EXPRESSION_LEXER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TDEL_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define TDEL_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/tdel_pkg.sv =====
package tdel_pkg;

  // default counter widths
  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF   = 16;

  // token field widths on the output channel
  localparam int KIND_W   = 4;
  localparam int START_W  = 24;
  localparam int LENGTH_W = 16;
  localparam int LINE_W   = 16;

  // result queue, power of two deep
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // byte classes
  typedef enum logic [3:0] {
    CL_SPACE, CL_NEWLINE, CL_DIGIT, CL_ZERO, CL_X, CL_HEX, CL_ALPHA, CL_DOT,
    CL_DQUOTE, CL_BSLASH, CL_SLASH, CL_OP, CL_LPAREN, CL_RPAREN, CL_NUL, CL_OTHER
  } cls_t;

  // scanner states
  typedef enum logic [3:0] {
    S_START, S_DEC, S_HEX, S_ZERO, S_FRAC, S_IDENT, S_STR, S_ESC, S_OPER, S_REMARK
  } lex_state_t;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    K_INT, K_FLOAT, K_IDENT, K_STRING, K_OP, K_OP2, K_LPAREN, K_RPAREN,
    K_COMMENT, K_END, K_ERROR
  } kind_t;

  // edge actions: advance, emit including byte, emit before byte, error
  typedef enum logic [1:0] {
    ACT_GO, ACT_EMIT, ACT_BACK, ACT_ERR
  } act_t;

  typedef struct packed {
    act_t       act;
    lex_state_t nxt;
    kind_t      kind;
  } edge_t;

  typedef struct packed {
    logic [KIND_W-1:0]   token_kind;
    logic [START_W-1:0]  token_start;
    logic [LENGTH_W-1:0] token_length;
    logic [LINE_W-1:0]   token_line;
    logic                last_of_run;
  } tok_t;

  // results of one byte handed to the queue
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_push_t;

  function automatic cls_t classify(logic [7:0] b);
    cls_t c;
    c = CL_OTHER;
    if (b inside {8'h20, 8'h09, 8'h0D})                       c = CL_SPACE;
    else if (b == 8'h0A)                                      c = CL_NEWLINE;
    else if (b == 8'h30)                                      c = CL_ZERO;
    else if (b inside {[8'h31:8'h39]})                        c = CL_DIGIT;
    else if (b inside {8'h78, 8'h58})                         c = CL_X;
    else if (b inside {[8'h61:8'h66], [8'h41:8'h46]})         c = CL_HEX;
    else if (b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F})  c = CL_ALPHA;
    else if (b == 8'h2E)                                      c = CL_DOT;
    else if (b == 8'h22)                                      c = CL_DQUOTE;
    else if (b == 8'h5C)                                      c = CL_BSLASH;
    else if (b == 8'h2F)                                      c = CL_SLASH;
    // + - * = < > ! & | ^ % ~
    else if (b inside {8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h3C, 8'h3E,
                       8'h21, 8'h26, 8'h7C, 8'h5E, 8'h25, 8'h7E}) c = CL_OP;
    else if (b == 8'h28)                                      c = CL_LPAREN;
    else if (b == 8'h29)                                      c = CL_RPAREN;
    else if (b == 8'h00)                                      c = CL_NUL;
    return c;
  endfunction

  function automatic edge_t mk_go(lex_state_t nxt);
    return '{act: ACT_GO, nxt: nxt, kind: K_INT};
  endfunction

  function automatic edge_t mk_emit(kind_t k);
    return '{act: ACT_EMIT, nxt: S_START, kind: k};
  endfunction

  function automatic edge_t mk_back(kind_t k);
    return '{act: ACT_BACK, nxt: S_START, kind: k};
  endfunction

  function automatic edge_t mk_err();
    return '{act: ACT_ERR, nxt: S_START, kind: K_ERROR};
  endfunction

  // transition table
  function automatic edge_t lex_edge(lex_state_t st, cls_t c);
    edge_t e;
    e = mk_err();
    case (st)
      S_DEC: begin
        if (c inside {CL_DIGIT, CL_ZERO})   e = mk_go(S_DEC);
        else if (c == CL_DOT)               e = mk_go(S_FRAC);
        else if (c == CL_OTHER)             e = mk_err();
        else                                e = mk_back(K_INT);
      end
      S_HEX: begin
        if (c inside {CL_DIGIT, CL_ZERO, CL_HEX}) e = mk_go(S_HEX);
        else if (c == CL_OTHER)                   e = mk_err();
        else                                      e = mk_back(K_INT);
      end
      S_ZERO: begin
        if (c inside {CL_DIGIT, CL_ZERO})   e = mk_go(S_DEC);
        else if (c == CL_X)                 e = mk_go(S_HEX);
        else if (c == CL_DOT)               e = mk_go(S_FRAC);
        else if (c == CL_OTHER)             e = mk_err();
        else                                e = mk_back(K_INT);
      end
      S_FRAC: begin
        if (c inside {CL_DIGIT, CL_ZERO})   e = mk_go(S_FRAC);
        else if (c == CL_OTHER)             e = mk_err();
        else                                e = mk_back(K_FLOAT);
      end
      S_IDENT: begin
        if (c inside {CL_DIGIT, CL_ZERO, CL_X, CL_HEX, CL_ALPHA}) e = mk_go(S_IDENT);
        else if (c == CL_OTHER)                                   e = mk_err();
        else                                                      e = mk_back(K_IDENT);
      end
      S_STR: begin
        if (c == CL_DQUOTE)                 e = mk_emit(K_STRING);
        else if (c == CL_BSLASH)            e = mk_go(S_ESC);
        else if (c == CL_NUL)               e = mk_err();
        else                                e = mk_go(S_STR);
      end
      S_ESC: begin
        if (c == CL_NUL)                    e = mk_err();
        else                                e = mk_go(S_STR);
      end
      S_OPER: begin
        if (c == CL_SLASH)                  e = mk_go(S_REMARK);
        else if (c == CL_OP)                e = mk_emit(K_OP2);
        else                                e = mk_back(K_OP);
      end
      S_REMARK: begin
        if (c inside {CL_NEWLINE, CL_NUL})  e = mk_back(K_COMMENT);
        else                                e = mk_go(S_REMARK);
      end
      default: begin
        // start state, and any code that is not a state
        if (c inside {CL_SPACE, CL_NEWLINE})            e = mk_go(S_START);
        else if (c == CL_DIGIT)                         e = mk_go(S_DEC);
        else if (c == CL_ZERO)                          e = mk_go(S_ZERO);
        else if (c inside {CL_X, CL_HEX, CL_ALPHA})     e = mk_go(S_IDENT);
        else if (c == CL_DQUOTE)                        e = mk_go(S_STR);
        else if (c inside {CL_SLASH, CL_OP})            e = mk_go(S_OPER);
        else if (c == CL_LPAREN)                        e = mk_emit(K_LPAREN);
        else if (c == CL_RPAREN)                        e = mk_emit(K_RPAREN);
        else if (c == CL_NUL)                           e = mk_emit(K_END);
        else                                            e = mk_err();
      end
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/core/tdel_ifs.sv =====
// source byte channel
interface tdel_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// token channel
interface tdel_token_if;
  logic                          valid;
  logic                          ready;
  logic [tdel_pkg::KIND_W-1:0]   token_kind;
  logic [tdel_pkg::START_W-1:0]  token_start;
  logic [tdel_pkg::LENGTH_W-1:0] token_length;
  logic [tdel_pkg::LINE_W-1:0]   token_line;
  logic                          last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_line, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_line, input last_of_run,
                output ready);
endinterface

// ===== rtl/core/tdel_step.sv =====
module tdel_step #(
  parameter int OFFSET_BITS = tdel_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = tdel_pkg::LINE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                drop_comments,
  input  logic                room,
  tdel_char_if.sink           char_ch,
  output tdel_pkg::tok_push_t push
);

  localparam int START_W  = tdel_pkg::START_W;
  localparam int LENGTH_W = tdel_pkg::LENGTH_W;
  localparam int LINE_W   = tdel_pkg::LINE_W;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;

  tdel_pkg::lex_state_t       lex_state, lex_state_next;
  logic [OFFSET_BITS-1:0]     byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0]     start_offset, start_offset_next;
  logic [LENGTH_W-1:0]        length_count, length_count_next;
  logic [LINE_BITS-1:0]       line_count, line_count_next;
  logic [LINE_BITS-1:0]       start_line, start_line_next;

  tdel_pkg::cls_t       cls;
  tdel_pkg::edge_t      e_first, e_restart, e_final;
  tdel_pkg::lex_state_t from_state;
  tdel_pkg::kind_t      final_kind;
  logic                 is_back, fresh, touch, final_emit;
  logic                 keep_back, keep_final;
  logic [OFFSET_BITS-1:0] offset_f;
  logic [LENGTH_W-1:0]    length_f;
  logic [LINE_BITS-1:0]   line_f;
  tdel_pkg::tok_t         back_tok, final_tok;

  // input register
  assign advance      = byte_valid && room;
  assign char_ch.ready = !rst && (!byte_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (char_ch.ready) begin
      byte_valid <= char_ch.valid;
    end
    if (char_ch.valid && char_ch.ready) begin
      byte_q <= char_ch.char_in;
    end
  end

  // scanner state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state     <= tdel_pkg::S_START;
      byte_position <= '0;
      start_offset  <= '0;
      length_count  <= '0;
      line_count    <= LINE_BITS'(1);
      start_line    <= LINE_BITS'(1);
    end else begin
      lex_state     <= lex_state_next;
      byte_position <= byte_position_next;
      start_offset  <= start_offset_next;
      length_count  <= length_count_next;
      line_count    <= line_count_next;
      start_line    <= start_line_next;
    end
  end

  // table lookup; a closing byte is rerun from start in the same cycle
  always_comb begin
    cls        = tdel_pkg::classify(byte_q);
    e_first    = tdel_pkg::lex_edge(lex_state, cls);
    e_restart  = tdel_pkg::lex_edge(tdel_pkg::S_START, cls);
    is_back    = (e_first.act == tdel_pkg::ACT_BACK);
    from_state = is_back ? tdel_pkg::S_START : lex_state;
    e_final    = is_back ? e_restart : e_first;
    fresh      = (from_state == tdel_pkg::S_START);
    touch      = !(e_final.act == tdel_pkg::ACT_GO && fresh &&
                   e_final.nxt == tdel_pkg::S_START);

    // open a new lexeme or extend the current one
    offset_f = start_offset;
    line_f   = start_line;
    length_f = length_count;
    if (touch) begin
      if (fresh) begin
        offset_f = byte_position;
        line_f   = line_count;
        length_f = LENGTH_W'(1);
      end else if (length_count != '1) begin
        length_f = length_count + 1'b1;
      end
    end

    final_emit = (e_final.act == tdel_pkg::ACT_EMIT) ||
                 (e_final.act == tdel_pkg::ACT_ERR);
    final_kind = (e_final.act == tdel_pkg::ACT_ERR) ? tdel_pkg::K_ERROR : e_final.kind;

    keep_back  = is_back && !(e_first.kind == tdel_pkg::K_COMMENT && drop_comments);
    keep_final = final_emit && !(final_kind == tdel_pkg::K_COMMENT && drop_comments);

    // token closed before this byte uses the old lexeme
    back_tok.token_kind   = e_first.kind;
    back_tok.token_start  = START_W'(start_offset);
    back_tok.token_length = length_count;
    back_tok.token_line   = LINE_W'(start_line);
    back_tok.last_of_run  = !keep_final;

    final_tok.token_kind   = final_kind;
    final_tok.token_start  = START_W'(offset_f);
    final_tok.token_length = length_f;
    final_tok.token_line   = LINE_W'(line_f);
    final_tok.last_of_run  = 1'b1;

    // next state, committed only when the byte moves on
    lex_state_next     = lex_state;
    byte_position_next = byte_position;
    start_offset_next  = start_offset;
    length_count_next  = length_count;
    line_count_next    = line_count;
    start_line_next    = start_line;
    if (advance) begin
      lex_state_next    = (e_final.act == tdel_pkg::ACT_GO) ? e_final.nxt : tdel_pkg::S_START;
      start_offset_next = offset_f;
      length_count_next = length_f;
      start_line_next   = line_f;
      if (byte_position != '1) begin
        byte_position_next = byte_position + 1'b1;
      end
      if (cls == tdel_pkg::CL_NEWLINE && line_count != '1) begin
        line_count_next = line_count + 1'b1;
      end
    end

    // results to the queue
    push.count  = advance ? ({1'b0, keep_back} + {1'b0, keep_final}) : 2'd0;
    push.first  = keep_back ? back_tok : final_tok;
    push.second = final_tok;
  end

endmodule

// ===== rtl/core/tdel_fifo.sv =====
module tdel_fifo (
  input  logic                clk,
  input  logic                rst,
  input  tdel_pkg::tok_push_t push,
  output logic                room,
  tdel_token_if.source        token_ch
);

  localparam int PTR_W = tdel_pkg::PTR_W;
  localparam int CNT_W = tdel_pkg::CNT_W;

  tdel_pkg::tok_t   mem [tdel_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  tdel_pkg::tok_t   head;

  // room for a full pair of results
  assign room = (count <= CNT_W'(tdel_pkg::FIFO_DEPTH - 2));
  assign pop  = token_ch.valid && token_ch.ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  // storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // head of queue drives the channel
  assign head                  = mem[rd_ptr];
  assign token_ch.valid        = (count != '0);
  assign token_ch.token_kind   = head.token_kind;
  assign token_ch.token_start  = head.token_start;
  assign token_ch.token_length = head.token_length;
  assign token_ch.token_line   = head.token_line;
  assign token_ch.last_of_run  = head.last_of_run;

endmodule

// ===== rtl/core/table_driven_expression_lexer.sv =====
// Expression lexer taking one source byte per item (0 marks end of input) and
// giving tokens with kind, start offset, length and start line. It accepts one
// byte every cycle while the result queue has room: the byte lands in an input
// register, then a class lookup and a transition-table lookup, rerun from start
// for a byte that closes a token, with the counter updates, write up to two
// tokens into a 4-entry result queue, from which they appear on the output.
// The queue hands out one token per cycle while the sink is ready, and the
// input stalls while it has fewer than two free entries, so a stream whose
// bytes each give at most one token runs at one byte per cycle while the sink
// is ready. drop_comments may only change while no byte is in flight.
`include "table_driven_expression_lexer_assert.svh"

module table_driven_expression_lexer #(
  parameter int OFFSET_BITS = tdel_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = tdel_pkg::LINE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_data,
  tdel_char_if.sink    char_ch,
  tdel_token_if.source token_ch
);

  logic                drop_comments;
  logic                room;
  tdel_pkg::tok_push_t push;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_comments <= 1'b0;
    end else if (cfg_write) begin
      drop_comments <= cfg_data;
    end
  end

  // scanner
  tdel_step #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .drop_comments (drop_comments),
    .room          (room),
    .char_ch       (char_ch),
    .push          (push)
  );

  // result queue
  tdel_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .token_ch (token_ch)
  );

  // checks
  `TDEL_ASSERT_NOW(a_push_has_room, clk, rst, push.count != 2'd0, room, "push without room")
  `TDEL_ASSERT_NOW(a_pair_marks, clk, rst, push.count == 2'd2, !push.first.last_of_run && push.second.last_of_run, "bad last_of_run in pair")
  `TDEL_ASSERT_NEXT(a_push_shows, clk, rst, push.count != 2'd0, token_ch.valid, "pushed token not shown")

endmodule

// ===== tb/tb_table_driven_expression_lexer.sv =====
module tb_table_driven_expression_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import tdel_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 195;
  localparam int TAIL_ITEMS    = 60;
  localparam int DIR_N         = 27;

  // byte pools for the random source text
  localparam string DIGITS    = "0123456789";
  localparam string HEXDIGITS = "0123456789abcdefABCDEF";
  localparam string LETTERS   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ALNUM     = "abcdefxyzXYZ_Qq0123456789";
  localparam string OPS       = "+-*=<>!&|^%~/";
  localparam string BLANKS    = " \t\r\n";
  localparam string TEXT      = "az AZ09_.+-*/()[]{}#@$;,:'?\t";
  localparam string ESCAPED   = "\"\\n0t";

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    tok_t       tok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  tdel_char_if  char_ch ();
  tdel_token_if token_ch ();

  table_driven_expression_lexer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .char_ch  (char_ch),
    .token_ch (token_ch)
  );

  // scanner model state
  lex_state_t          scan_state;
  logic [START_W-1:0]  scan_pos;
  logic [START_W-1:0]  lex_start;
  logic [LENGTH_W-1:0] tok_len;
  logic [LINE_W-1:0]   cur_line;
  logic [LINE_W-1:0]   tok_line;
  logic                drop_cfg;

  // tokens caused by the latest byte
  tok_t step_tok [2];
  int   step_cnt;

  tok_t       tokens_due [$];
  logic [7:0] src_bytes [$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  bit         sender_gaps  = 1'b1;

  // directed source text, expected token typed in where it is obvious
  dir_row_t dir_rows [DIR_N] = '{
    '{"(",   1'b1, '{K_LPAREN, 24'd0, 16'd1, 16'd1, 1'b1}},
    '{8'h00, 1'b1, '{K_END,    24'd1, 16'd1, 16'd1, 1'b1}},
    '{8'hFF, 1'b1, '{K_ERROR,  24'd2, 16'd1, 16'd1, 1'b1}},
    '{8'h80, 1'b1, '{K_ERROR,  24'd3, 16'd1, 16'd1, 1'b1}},
    '{"0",   1'b0, '0},
    '{"x",   1'b0, '0},
    '{"F",   1'b0, '0},
    '{")",   1'b0, '0},
    '{"1",   1'b0, '0},
    '{".",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{"\n",  1'b0, '0},
    '{"\"",  1'b0, '0},
    '{"\\",  1'b0, '0},
    '{"\"",  1'b0, '0},
    '{"\n",  1'b0, '0},
    '{"\"",  1'b0, '0},
    '{"<",   1'b0, '0},
    '{"=",   1'b0, '0},
    '{"/",   1'b0, '0},
    '{"/",   1'b0, '0},
    '{"\n",  1'b0, '0},
    '{"-",   1'b0, '0},
    '{"a",   1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{"7",   1'b0, '0},
    '{8'h7F, 1'b0, '0}
  };

  always #5ns clk = ~clk;

  // byte classes
  function automatic cls_t byte_class(logic [7:0] b);
    cls_t c;
    c = CL_OTHER;
    if (b == " " || b == "\t" || b == "\r") c = CL_SPACE;
    else if (b == "\n") c = CL_NEWLINE;
    else if (b == "0") c = CL_ZERO;
    else if (b >= "1" && b <= "9") c = CL_DIGIT;
    else if (b == "x" || b == "X") c = CL_X;
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) c = CL_HEX;
    else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") c = CL_ALPHA;
    else if (b == ".") c = CL_DOT;
    else if (b == "\"") c = CL_DQUOTE;
    else if (b == "\\") c = CL_BSLASH;
    else if (b == "/") c = CL_SLASH;
    else if (b == "+" || b == "-" || b == "*" || b == "=" || b == "<" || b == ">" ||
             b == "!" || b == "&" || b == "|" || b == "^" || b == "%" || b == "~")
      c = CL_OP;
    else if (b == "(") c = CL_LPAREN;
    else if (b == ")") c = CL_RPAREN;
    else if (b == 8'h00) c = CL_NUL;
    return c;
  endfunction

  function automatic edge_t go_edge(lex_state_t s);
    edge_t e;
    e.act  = ACT_GO;
    e.nxt  = s;
    e.kind = K_INT;
    return e;
  endfunction

  function automatic edge_t out_edge(act_t a, kind_t k);
    edge_t e;
    e.act  = a;
    e.nxt  = S_START;
    e.kind = k;
    return e;
  endfunction

  // transition of the scanner for one state and byte class
  function automatic edge_t scan_edge(lex_state_t st, cls_t c);
    edge_t e;
    e = out_edge(ACT_ERR, K_ERROR);
    case (st)
      S_DEC, S_ZERO, S_HEX, S_FRAC, S_IDENT: begin
        // the token closes before any byte that cannot extend it; a CL_OTHER byte is an error
        if (c != CL_OTHER)
          e = out_edge(ACT_BACK, st == S_FRAC ? K_FLOAT : (st == S_IDENT ? K_IDENT : K_INT));
        if (c == CL_DIGIT || c == CL_ZERO) e = go_edge(st == S_ZERO ? S_DEC : st);
        else if (c == CL_DOT && (st == S_DEC || st == S_ZERO)) e = go_edge(S_FRAC);
        else if (c == CL_X && st == S_ZERO) e = go_edge(S_HEX);
        else if ((c == CL_X || c == CL_ALPHA) && st == S_IDENT) e = go_edge(S_IDENT);
        else if (c == CL_HEX && (st == S_HEX || st == S_IDENT)) e = go_edge(st);
      end
      S_STR: begin
        if (c == CL_DQUOTE) e = out_edge(ACT_EMIT, K_STRING);
        else if (c == CL_BSLASH) e = go_edge(S_ESC);
        else if (c != CL_NUL) e = go_edge(S_STR);
      end
      S_ESC: begin
        if (c != CL_NUL) e = go_edge(S_STR);
      end
      S_OPER: begin
        if (c == CL_SLASH) e = go_edge(S_REMARK);
        else if (c == CL_OP) e = out_edge(ACT_EMIT, K_OP2);
        else e = out_edge(ACT_BACK, K_OP);
      end
      S_REMARK: begin
        if (c == CL_NEWLINE || c == CL_NUL) e = out_edge(ACT_BACK, K_COMMENT);
        else e = go_edge(S_REMARK);
      end
      default: begin
        case (c)
          CL_SPACE, CL_NEWLINE:     e = go_edge(S_START);
          CL_DIGIT:                 e = go_edge(S_DEC);
          CL_ZERO:                  e = go_edge(S_ZERO);
          CL_X, CL_HEX, CL_ALPHA:   e = go_edge(S_IDENT);
          CL_DQUOTE:                e = go_edge(S_STR);
          CL_SLASH, CL_OP:          e = go_edge(S_OPER);
          CL_LPAREN:                e = out_edge(ACT_EMIT, K_LPAREN);
          CL_RPAREN:                e = out_edge(ACT_EMIT, K_RPAREN);
          CL_NUL:                   e = out_edge(ACT_EMIT, K_END);
          default:                  e = out_edge(ACT_ERR, K_ERROR);
        endcase
      end
    endcase
    return e;
  endfunction

  // a token starts here or grows by one byte
  task automatic open_or_grow();
    if (scan_state == S_START) begin
      lex_start = scan_pos;
      tok_line  = cur_line;
      tok_len   = LENGTH_W'(1);
    end else if (~&tok_len) begin
      tok_len = tok_len + 1'b1;
    end
  endtask

  // byte consumed: offset and line counters, both saturating
  task automatic advance(cls_t c);
    if (~&scan_pos) scan_pos = scan_pos + 1'b1;
    if (c == CL_NEWLINE && ~&cur_line) cur_line = cur_line + 1'b1;
  endtask

  task automatic emit_tok(kind_t k);
    if (!(k == K_COMMENT && drop_cfg)) begin
      step_tok[step_cnt] = '{k, lex_start, tok_len, tok_line, 1'b0};
      step_cnt++;
    end
  endtask

  // tokens caused by one source byte, with a re-run from start after a close
  task automatic lex_byte(logic [7:0] b);
    cls_t  c;
    edge_t e;
    c = byte_class(b);
    step_cnt = 0;
    for (int pass = 0; pass < 2; pass++) begin
      e = scan_edge(scan_state, c);
      if (e.act == ACT_BACK) begin
        emit_tok(e.kind);
        scan_state = S_START;
      end else begin
        if (e.act != ACT_GO || scan_state != S_START || e.nxt != S_START) open_or_grow();
        if (e.act != ACT_GO) emit_tok(e.act == ACT_EMIT ? e.kind : K_ERROR);
        advance(c);
        scan_state = e.nxt;
        break;
      end
    end
    if (step_cnt > 0) step_tok[step_cnt-1].last_of_run = 1'b1;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one item on the byte channel, tokens predicted when it is taken
  task automatic send_byte(logic [7:0] b, bit typed = 1'b0, tok_t want = '0);
    int gap;
    char_ch.valid   <= 1'b1;
    char_ch.char_in <= b;
    do @(posedge clk); while (!char_ch.ready);
    lex_byte(b);
    if (typed) tokens_due.push_back(want);
    else for (int i = 0; i < step_cnt; i++) tokens_due.push_back(step_tok[i]);
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every token is out and the pipe is empty
  task automatic wait_until_idle();
    if (char_ch.valid) char_ch.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_drop(logic v);
    wait_until_idle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    drop_cfg = v;
  endtask

  // one lexeme of random content, mostly well formed, some noise
  task automatic add_fragment();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 5);
      repeat (n) src_bytes.push_back(pick(DIGITS));
    end else if (r < 20) begin
      src_bytes.push_back("0");
      src_bytes.push_back(pick("xX"));
      n = $urandom_range(1, 4);
      repeat (n) src_bytes.push_back(pick(HEXDIGITS));
    end else if (r < 28) begin
      n = $urandom_range(1, 3);
      repeat (n) src_bytes.push_back(pick(DIGITS));
      src_bytes.push_back(".");
      n = $urandom_range(0, 3);
      repeat (n) src_bytes.push_back(pick(DIGITS));
    end else if (r < 42) begin
      src_bytes.push_back(pick(LETTERS));
      n = $urandom_range(0, 5);
      repeat (n) src_bytes.push_back(pick(ALNUM));
    end else if (r < 50) begin
      // string with escapes and line breaks, now and then cut by end of input
      src_bytes.push_back("\"");
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: begin
            src_bytes.push_back("\\");
            src_bytes.push_back(pick(ESCAPED));
          end
          1: src_bytes.push_back("\n");
          default: src_bytes.push_back(pick(TEXT));
        endcase
      end
      case ($urandom_range(0, 19))
        0: src_bytes.push_back(8'h00);
        1: begin
          src_bytes.push_back("\\");
          src_bytes.push_back(8'h00);
        end
        default: src_bytes.push_back("\"");
      endcase
    end else if (r < 60) begin
      src_bytes.push_back(pick(OPS));
      if ($urandom_range(0, 1)) src_bytes.push_back(pick(OPS));
    end else if (r < 66) begin
      src_bytes.push_back(pick("()"));
    end else if (r < 72) begin
      src_bytes.push_back("/");
      src_bytes.push_back("/");
      n = $urandom_range(0, 8);
      repeat (n) src_bytes.push_back(pick(TEXT));
      src_bytes.push_back(($urandom_range(0, 6) == 0) ? 8'h00 : "\n");
    end else if (r < 78) begin
      n = $urandom_range(1, 3);
      repeat (n) src_bytes.push_back(pick(BLANKS));
    end else if (r < 82) begin
      src_bytes.push_back(8'h00);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) src_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) src_bytes.push_back(pick(BLANKS));
  endtask

  task automatic send_random(int count);
    for (int k = 0; k < count; k++) begin
      if (src_bytes.size() == 0) add_fragment();
      send_byte(src_bytes.pop_front());
    end
  endtask

  // stimulus
  initial begin
    scan_state = S_START;
    scan_pos   = '0;
    lex_start  = '0;
    tok_len    = '0;
    cur_line   = LINE_W'(1);
    tok_line   = LINE_W'(1);
    drop_cfg   = 1'b0;
    char_ch.valid   <= 1'b0;
    char_ch.char_in <= 8'h00;
    cfg_write       <= 1'b0;
    cfg_data        <= 1'b0;
    rst             <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_drop(1'b0);

    // directed text
    for (int i = 0; i < DIR_N; i++) send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].tok);

    // random text, comment dropping toggled between phases
    for (int p = 0; p < PHASES; p++) begin
      set_drop(!p[0]);
      send_random(PHASE_ITEMS);
    end

    // back-to-back stretch with no gaps on the sender side
    sender_gaps = 1'b0;
    send_random(TAIL_ITEMS);
    sender_gaps = 1'b1;

    wait_until_idle();
    if (mismatches == 0) $display("table_driven_expression_lexer: match");
    else $display("table_driven_expression_lexer: mismatch");
    $finish;
  end

  // token sink with random stalls and stall-free stretches
  initial begin
    int gap;
    token_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      token_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8))
        @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        token_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each token item with the oldest prediction
  always @(posedge clk) begin
    tok_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: token expected none, got kind %0d start %0d length %0d line %0d",
                 $time, token_ch.token_kind, token_ch.token_start, token_ch.token_length,
                 token_ch.token_line);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", want.token_kind, token_ch.token_kind);
        check_field("token_start", want.token_start, token_ch.token_start);
        check_field("token_length", want.token_length, token_ch.token_length);
        check_field("token_line", want.token_line, token_ch.token_line);
        check_field("last_of_run", want.last_of_run, token_ch.last_of_run);
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (token_ch.valid && token_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("table_driven_expression_lexer: mismatch");
      $finish;
    end
  end

endmodule
